### hw/rtl/mfrf_pkg.sv
// Shared constants, types and state codes of the mesh flood relay filter.
package mfrf_pkg;

	localparam int SEEN_DEPTH = 32;
	localparam int SEEN_AW    = $clog2(SEEN_DEPTH);
	localparam int SEEN_CW    = $clog2(SEEN_DEPTH + 1);

	localparam int NB_DEPTH = 10;
	localparam int NB_AW    = (NB_DEPTH > 1) ? $clog2(NB_DEPTH) : 1;
	localparam int NB_CW    = $clog2(NB_DEPTH + 1);

	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 24;

	localparam logic [1:0] TYPE_DATA   = 2'd0;
	localparam logic [1:0] TYPE_BEACON = 2'd2;

	localparam logic [15:0] MY_NODE_RESET = 16'd1;

	typedef struct packed {
		logic [31:0]        stamp;
		logic signed [8:0]  strength;
		logic [15:0]        id;
	} nb_entry_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SEEN  = 5'b00010,
		ST_NB    = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

### hw/rtl/mfrf_ram.sv
// Simple dual-port RAM, one write port and one registered read port.
module mfrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/mesh_flood_relay_filter.sv
// Mesh flood relay filter: accepts a header word, walks the seen-id ring and the neighbour
// table out of RAM one entry a cycle, then posts one result word.
// A duplicate hit in the ring ends the ring walk and skips the neighbour walk and the update.
// Headers are taken only in idle, after the previous result word is loaded for output, so an
// m_tready stall also holds off the next header.
// Reset clears valid bits, ring pointer, neighbour count and my_node (to 1); RAM is not cleared.
module mesh_flood_relay_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [15:0]                       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pkt_id[31:0], src_node[47:32], dst_broadcast[48], dst_node[64:49],
	// hops_left[72:65], signal_dbm[81:73], now_ms[113:82], zero fill
	input  logic [mfrf_pkg::IN_TDATA_W-1:0]   s_tdata,
	// pkt_type[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// duplicate[0], deliver[1], relay[2], relay_hops[10:3], neighbour_slot[14:11],
	// neighbour_new[15], neighbour_dropped[16], zero fill
	output logic [mfrf_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	mfrf_pkg::state_t state_q;

	logic [15:0]       my_node_q;

	logic [31:0]       id_q;
	logic [15:0]       src_q;
	logic              bcast_q;
	logic [15:0]       dst_q;
	logic [1:0]        type_q;
	logic [7:0]        hops_q;
	logic signed [8:0] sig_q;
	logic [31:0]       now_q;

	// seen ring
	logic [mfrf_pkg::SEEN_DEPTH-1:0] seen_valid_q;
	logic [mfrf_pkg::SEEN_AW-1:0]    seen_ptr_q;
	logic [mfrf_pkg::SEEN_CW-1:0]    scnt_q;
	logic                            s_cmp_s1;
	logic [mfrf_pkg::SEEN_AW-1:0]    s_idx_s1;
	logic                            seen_re;
	logic                            seen_we;
	logic [31:0]                     seen_rdata;
	logic                            seen_hit;
	logic                            seen_end;

	// neighbour table
	logic [mfrf_pkg::NB_CW-1:0]      nb_total_q;
	logic [mfrf_pkg::NB_CW-1:0]      ncnt_q;
	logic                            n_cmp_s1;
	logic [mfrf_pkg::NB_AW-1:0]      n_idx_s1;
	logic                            found_q;
	logic [mfrf_pkg::NB_AW-1:0]      found_slot_q;
	logic                            nb_re;
	logic                            nb_we;
	logic [mfrf_pkg::NB_AW-1:0]      nb_waddr;
	mfrf_pkg::nb_entry_t             nb_wdata;
	mfrf_pkg::nb_entry_t             nb_rdata;
	logic                            nb_hit;
	logic                            nb_end;
	logic                            nb_room;

	// result
	logic       dup_q;
	logic       deliver_q;
	logic       relay_q;
	logic [7:0] rhops_q;
	logic [3:0] slot_q;
	logic       new_q;
	logic       dropped_q;

	logic                              m_tvalid_q;
	logic [mfrf_pkg::OUT_TDATA_W-1:0]  m_tdata_q;
	logic                              out_load;

	assign s_tready = (state_q == mfrf_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign seen_re  = (state_q == mfrf_pkg::ST_SEEN) &&
	                  (scnt_q < mfrf_pkg::SEEN_CW'(mfrf_pkg::SEEN_DEPTH));
	assign seen_hit = (state_q == mfrf_pkg::ST_SEEN) && s_cmp_s1 &&
	                  seen_valid_q[s_idx_s1] && (seen_rdata == id_q);
	assign seen_end = (state_q == mfrf_pkg::ST_SEEN) && !s_cmp_s1 &&
	                  (scnt_q == mfrf_pkg::SEEN_CW'(mfrf_pkg::SEEN_DEPTH));
	assign seen_we  = seen_end;

	assign nb_re   = (state_q == mfrf_pkg::ST_NB) && (ncnt_q < nb_total_q);
	assign nb_hit  = (state_q == mfrf_pkg::ST_NB) && n_cmp_s1 && (nb_rdata.id == src_q);
	assign nb_end  = (state_q == mfrf_pkg::ST_NB) && !n_cmp_s1 && (ncnt_q == nb_total_q);
	assign nb_room = (nb_total_q < mfrf_pkg::NB_CW'(mfrf_pkg::NB_DEPTH));

	// refresh a known source or append a new one
	assign nb_we    = (state_q == mfrf_pkg::ST_WRITE) && (found_q || nb_room);
	assign nb_waddr = found_q ? found_slot_q : nb_total_q[mfrf_pkg::NB_AW-1:0];

	always_comb begin
		nb_wdata          = '0;
		nb_wdata.stamp    = now_q;
		nb_wdata.strength = sig_q;
		nb_wdata.id       = src_q;
	end

	assign out_load = (state_q == mfrf_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	mfrf_ram #(
		.WIDTH (32),
		.DEPTH (mfrf_pkg::SEEN_DEPTH),
		.AW    (mfrf_pkg::SEEN_AW)
	) u_seen_ram (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_ptr_q),
		.wdata (id_q),
		.re    (seen_re),
		.raddr (scnt_q[mfrf_pkg::SEEN_AW-1:0]),
		.rdata (seen_rdata)
	);

	mfrf_ram #(
		.WIDTH ($bits(mfrf_pkg::nb_entry_t)),
		.DEPTH (mfrf_pkg::NB_DEPTH),
		.AW    (mfrf_pkg::NB_AW)
	) u_nb_ram (
		.clk   (clk),
		.we    (nb_we),
		.waddr (nb_waddr),
		.wdata (nb_wdata),
		.re    (nb_re),
		.raddr (ncnt_q[mfrf_pkg::NB_AW-1:0]),
		.rdata (nb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_node_q <= mfrf_pkg::MY_NODE_RESET;
		end else if (cfg_we) begin
			my_node_q <= cfg_wdata;
		end
	end

	// header capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			id_q    <= s_tdata[31:0];
			src_q   <= s_tdata[47:32];
			bcast_q <= s_tdata[48];
			dst_q   <= s_tdata[64:49];
			hops_q  <= s_tdata[72:65];
			sig_q   <= s_tdata[81:73];
			now_q   <= s_tdata[113:82];
			type_q  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mfrf_pkg::ST_IDLE;
			seen_valid_q <= '0;
			seen_ptr_q   <= '0;
			scnt_q       <= '0;
			s_cmp_s1     <= 1'b0;
			nb_total_q   <= '0;
			ncnt_q       <= '0;
			n_cmp_s1     <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			s_cmp_s1 <= seen_re;
			n_cmp_s1 <= nb_re;
			unique case (state_q)
				mfrf_pkg::ST_IDLE: begin
					scnt_q  <= '0;
					ncnt_q  <= '0;
					found_q <= 1'b0;
					if (s_tvalid) begin
						state_q <= mfrf_pkg::ST_SEEN;
					end
				end
				mfrf_pkg::ST_SEEN: begin
					if (seen_re) begin
						scnt_q <= scnt_q + 1'b1;
					end
					if (seen_hit) begin
						state_q <= mfrf_pkg::ST_DONE;
					end else if (seen_end) begin
						seen_valid_q[seen_ptr_q] <= 1'b1;
						if (seen_ptr_q == mfrf_pkg::SEEN_AW'(mfrf_pkg::SEEN_DEPTH - 1)) begin
							seen_ptr_q <= '0;
						end else begin
							seen_ptr_q <= seen_ptr_q + 1'b1;
						end
						state_q <= mfrf_pkg::ST_NB;
					end
				end
				mfrf_pkg::ST_NB: begin
					if (nb_re) begin
						ncnt_q <= ncnt_q + 1'b1;
					end
					if (nb_hit) begin
						found_q <= 1'b1;
						state_q <= mfrf_pkg::ST_WRITE;
					end else if (nb_end) begin
						state_q <= mfrf_pkg::ST_WRITE;
					end
				end
				mfrf_pkg::ST_WRITE: begin
					if (!found_q && nb_room) begin
						nb_total_q <= nb_total_q + 1'b1;
					end
					state_q <= mfrf_pkg::ST_DONE;
				end
				mfrf_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= mfrf_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mfrf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// compare index tracks the read issued in the previous cycle
	always_ff @(posedge clk) begin
		s_idx_s1 <= scnt_q[mfrf_pkg::SEEN_AW-1:0];
		n_idx_s1 <= ncnt_q[mfrf_pkg::NB_AW-1:0];
		if (nb_hit) begin
			found_slot_q <= n_idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mfrf_pkg::ST_IDLE: begin
				dup_q     <= 1'b0;
				deliver_q <= 1'b0;
				relay_q   <= 1'b0;
				rhops_q   <= '0;
				slot_q    <= '0;
				new_q     <= 1'b0;
				dropped_q <= 1'b0;
			end
			mfrf_pkg::ST_SEEN: begin
				if (seen_hit) begin
					dup_q <= 1'b1;
				end
			end
			mfrf_pkg::ST_WRITE: begin
				if (found_q) begin
					slot_q <= 4'(found_slot_q);
				end else if (nb_room) begin
					slot_q <= 4'(nb_total_q);
					new_q  <= 1'b1;
				end else begin
					dropped_q <= 1'b1;
				end
				if (type_q != mfrf_pkg::TYPE_BEACON) begin
					deliver_q <= (type_q == mfrf_pkg::TYPE_DATA) &&
					             (bcast_q || (dst_q == my_node_q));
					if (bcast_q && (hops_q > 8'd1)) begin
						relay_q <= 1'b1;
						rhops_q <= hops_q - 8'd1;
					end
				end
			end
			mfrf_pkg::ST_NB, mfrf_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {7'd0, dropped_q, new_q, slot_q, rhops_q, relay_q, deliver_q, dup_q};
		end
	end

endmodule

### tb/mesh_flood_relay_filter_chk.sv
// Checker for the mesh flood relay filter: watches both streams, predicts each result word and compares.
module mesh_flood_relay_filter_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [15:0]                       cfg_wdata,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [mfrf_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [1:0]                        s_tuser,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [mfrf_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output int                                errors,
	output int                                pending,
	output int                                dup_total,
	output int                                drop_total
);

	// result word layout, lowest bit last
	typedef struct packed {
		logic       dropped;
		logic       is_new;
		logic [3:0] slot;
		logic [7:0] relay_hops;
		logic       relay;
		logic       deliver;
		logic       duplicate;
	} verdict_t;

	logic [15:0]       node_id;
	logic [31:0]       ring_ids [mfrf_pkg::SEEN_DEPTH];
	bit                seen_live [mfrf_pkg::SEEN_DEPTH];
	int unsigned       seen_wr;
	logic [15:0]       nb_src [mfrf_pkg::NB_DEPTH];
	logic signed [8:0] nb_rssi [mfrf_pkg::NB_DEPTH];
	logic [31:0]       nb_stamp [mfrf_pkg::NB_DEPTH];
	int unsigned       nb_fill;
	verdict_t          verdict_q [$];

	// applies one header to the ring and table copies and returns the routing verdict
	function automatic verdict_t route_header(logic [31:0] id, logic [15:0] src, logic bcast,
			logic [15:0] dst, logic [1:0] kind, logic [7:0] hops, logic signed [8:0] rssi,
			logic [31:0] stamp);
		verdict_t v;
		bit hit;
		bit known;
		int i;
		v = '0;
		hit = 0;
		known = 0;
		for (i = 0; i < mfrf_pkg::SEEN_DEPTH; i++) begin
			if (seen_live[i] && ring_ids[i] == id)
				hit = 1;
		end
		if (hit) begin
			v.duplicate = 1'b1;
			return v;
		end
		ring_ids[seen_wr] = id;
		seen_live[seen_wr] = 1;
		seen_wr = (seen_wr + 1) % mfrf_pkg::SEEN_DEPTH;

		for (i = 0; i < nb_fill && !known; i++) begin
			if (nb_src[i] == src) begin
				nb_rssi[i] = rssi;
				nb_stamp[i] = stamp;
				v.slot = 4'(i);
				known = 1;
			end
		end
		if (!known) begin
			if (nb_fill < mfrf_pkg::NB_DEPTH) begin
				nb_src[nb_fill] = src;
				nb_rssi[nb_fill] = rssi;
				nb_stamp[nb_fill] = stamp;
				v.slot = 4'(nb_fill);
				v.is_new = 1'b1;
				nb_fill++;
			end else begin
				v.dropped = 1'b1;
			end
		end

		// beacons update state but are never delivered or forwarded
		if (kind != mfrf_pkg::TYPE_BEACON) begin
			v.deliver = (kind == mfrf_pkg::TYPE_DATA) && (bcast || dst == node_id);
			if (bcast && hops > 8'd1) begin
				v.relay = 1'b1;
				v.relay_hops = hops - 8'd1;
			end
		end
		return v;
	endfunction

	task automatic cmp_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		verdict_t got;
		if (!arst_n) begin
			node_id = mfrf_pkg::MY_NODE_RESET;
			seen_wr = 0;
			nb_fill = 0;
			foreach (seen_live[i])
				seen_live[i] = 0;
			verdict_q.delete();
			errors = 0;
			dup_total = 0;
			drop_total = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				node_id = cfg_wdata;

			// drain first so a word leaving on the same edge matches the older header
			if (m_tvalid && m_tready) begin
				got = verdict_t'(m_tdata[16:0]);
				if (verdict_q.size() == 0) begin
					$display("%0t: result word %0h with nothing expected", $time, m_tdata);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					cmp_field("duplicate", 32'(want.duplicate), 32'(got.duplicate));
					cmp_field("deliver", 32'(want.deliver), 32'(got.deliver));
					cmp_field("relay", 32'(want.relay), 32'(got.relay));
					cmp_field("relay_hops", 32'(want.relay_hops), 32'(got.relay_hops));
					cmp_field("neighbour_slot", 32'(want.slot), 32'(got.slot));
					cmp_field("neighbour_new", 32'(want.is_new), 32'(got.is_new));
					cmp_field("neighbour_dropped", 32'(want.dropped), 32'(got.dropped));
				end
			end

			if (s_tvalid && s_tready) begin
				want = route_header(s_tdata[31:0], s_tdata[47:32], s_tdata[48], s_tdata[64:49],
					s_tuser, s_tdata[72:65], s_tdata[81:73], s_tdata[113:82]);
				dup_total += int'(want.duplicate);
				drop_total += int'(want.dropped);
				verdict_q.push_back(want);
			end
			pending <= verdict_q.size();
		end
	end

endmodule

### tb/mesh_flood_relay_filter_tb.sv
// Testbench top for the mesh flood relay filter: clock, reset, header stimulus and verdict.
module mesh_flood_relay_filter_tb;

	localparam logic [1:0] TYPE_ACK   = 2'd1;
	localparam logic [1:0] TYPE_OTHER = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int WORDS_PER_PHASE = 258;
	localparam int CALM_TAIL = 150;

	typedef struct packed {
		logic [31:0]       pkt_id;
		logic [15:0]       src_node;
		logic              dst_broadcast;
		logic [15:0]       dst_node;
		logic [1:0]        pkt_type;
		logic [7:0]        hops_left;
		logic signed [8:0] signal_dbm;
		logic [31:0]       now_ms;
	} header_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [15:0]                      cfg_wdata;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [mfrf_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic [1:0]                       s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [mfrf_pkg::OUT_TDATA_W-1:0] m_tdata;

	int          errors;
	int          pending;
	int          dup_total;
	int          drop_total;
	int          cycles;
	int          words_sent;
	int          settings_used;
	int          stall_left;
	bit          calm;
	logic [15:0] node_id;
	logic [31:0] id_hist [$];
	logic [15:0] known_src [10] = '{16'h0000, 16'hFFFF, 16'd100, 16'd101, 16'd102, 16'd103,
		16'd104, 16'd105, 16'd106, 16'd107};
	logic [15:0] node_settings [5];

	mesh_flood_relay_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	mesh_flood_relay_filter_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.errors     (errors),
		.pending    (pending),
		.dup_total  (dup_total),
		.drop_total (drop_total)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still outstanding", cycles, pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result stalls come in bursts, which start only while bit 9 of the cycle count is clear
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && !cycles[9] && $urandom_range(0, 99) < 6) begin
			stall_left <= $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic header_t mk(logic [31:0] id, logic [15:0] src, logic bcast,
			logic [15:0] dst, logic [1:0] kind, logic [7:0] hops, logic signed [8:0] rssi,
			logic [31:0] stamp);
		header_t h;
		h = '{id, src, bcast, dst, kind, hops, rssi, stamp};
		return h;
	endfunction

	task automatic push_header(header_t h, bit may_idle);
		if (may_idle && !calm && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tdata <= {6'd0, h.now_ms, h.signal_dbm, h.hops_left, h.dst_node, h.dst_broadcast,
			h.src_node, h.pkt_id};
		s_tuser <= h.pkt_type;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		id_hist.push_back(h.pkt_id);
		if (id_hist.size() > 48)
			void'(id_hist.pop_front());
	endtask

	// mostly fresh ids, a quarter replayed from recent traffic, some of it already evicted
	function automatic header_t random_header();
		header_t h;
		int sel;
		if (id_hist.size() > 0 && $urandom_range(0, 99) < 25)
			h.pkt_id = id_hist[$urandom_range(0, id_hist.size() - 1)];
		else
			h.pkt_id = $urandom();
		sel = $urandom_range(0, 9);
		if (sel < 7)
			h.src_node = known_src[$urandom_range(0, 9)];
		else if (sel < 9)
			h.src_node = 16'(108 + $urandom_range(0, 3));
		else
			h.src_node = 16'($urandom());
		h.dst_broadcast = ($urandom_range(0, 99) < 40);
		sel = $urandom_range(0, 9);
		if (sel < 5)
			h.dst_node = node_id;
		else if (sel < 6)
			h.dst_node = node_id + 16'd1;
		else
			h.dst_node = 16'($urandom());
		h.pkt_type = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 5))
			0: h.hops_left = 8'd0;
			1: h.hops_left = 8'd1;
			2: h.hops_left = 8'd2;
			3: h.hops_left = 8'd255;
			default: h.hops_left = 8'($urandom());
		endcase
		h.signal_dbm = -$signed({1'b0, 8'($urandom_range(0, 200))});
		h.now_ms = $urandom();
		return h;
	endfunction

	task automatic random_run(int count, bit last_phase);
		int n;
		for (n = 0; n < count; n++) begin
			calm = last_phase && (n >= count - CALM_TAIL);
			// bursts of back-to-back words between idling stretches
			push_header(random_header(), (n % 100) < 70);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_node(logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		node_id = value;
		settings_used++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int k;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 16'd0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= mfrf_pkg::TYPE_DATA;
		calm = 0;
		words_sent = 0;
		settings_used = 1;
		node_id = mfrf_pkg::MY_NODE_RESET;
		node_settings = '{16'h0000, 16'hFFFF, 16'h8000, 16'($urandom()), 16'($urandom())};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: id zero, extremes, every type, addressed vs broadcast, hop limits
		push_header(mk(32'h0, 16'h0000, 1'b1, 16'h0, mfrf_pkg::TYPE_DATA, 8'd255, 9'sd0,
			32'h0), 1);
		push_header(mk(32'h0, 16'h0000, 1'b1, 16'h0, mfrf_pkg::TYPE_DATA, 8'd255, 9'sd0,
			32'h0), 1);
		push_header(mk(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'd1, mfrf_pkg::TYPE_DATA, 8'd0,
			-9'sd200, 32'hFFFF_FFFF), 0);
		push_header(mk(32'd1, 16'hFFFF, 1'b0, 16'd2, mfrf_pkg::TYPE_DATA, 8'd5, -9'sd1,
			32'd7), 0);
		push_header(mk(32'd2, 16'h0000, 1'b1, 16'hFFFF, mfrf_pkg::TYPE_BEACON, 8'd10, -9'sd90,
			32'd8), 1);
		push_header(mk(32'd3, 16'h0000, 1'b1, 16'd1, TYPE_ACK, 8'd1, -9'sd50, 32'd9), 0);
		push_header(mk(32'd4, 16'hFFFF, 1'b1, 16'd0, TYPE_OTHER, 8'd2, -9'sd100, 32'd10), 0);
		push_header(mk(32'd5, 16'h0000, 1'b1, 16'd1, mfrf_pkg::TYPE_DATA, 8'd0, -9'sd3,
			32'd11), 1);
		push_header(mk(32'd6, 16'hFFFF, 1'b0, 16'hFFFF, TYPE_ACK, 8'd200, -9'sd20, 32'd12), 0);
		push_header(mk(32'd7, 16'h0000, 1'b0, 16'd1, mfrf_pkg::TYPE_BEACON, 8'd3, -9'sd60,
			32'd13), 0);
		// fill the neighbour table; the last new source finds it full
		for (k = 0; k < 9; k++)
			push_header(mk(32'd100 + k, 16'(100 + k), 1'b1, 16'd0, TYPE_OTHER, 8'd4, -9'sd70,
				32'd200 + k), (k % 2) != 0);
		push_header(mk(32'hFFFF_FFFF, 16'd42, 1'b1, 16'd1, mfrf_pkg::TYPE_DATA, 8'd9, -9'sd1,
			32'd1), 0);
		push_header(mk(32'hDEAD_BEEF, 16'd105, 1'b1, 16'd1, mfrf_pkg::TYPE_DATA, 8'd9, -9'sd1,
			32'd2), 0);

		random_run(60, 0);
		foreach (node_settings[p]) begin
			settle();
			write_node(node_settings[p]);
			random_run(WORDS_PER_PHASE, p == 4);
		end
		settle();
		repeat (64) @(posedge clk);

		$display("%0d headers sent under %0d node id settings", words_sent, settings_used);
		$display("%0d duplicates suppressed, %0d sources left out of a full table",
			dup_total, drop_total);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
